[sv/tsl_pkg.sv]
// Package for the template select / linearity interpolation block.
// Field widths, command and status codes, and the table entry type.
// No dependencies.
package tsl_pkg;

    localparam int CMD_W    = 2;
    localparam int AREA_W   = 32;
    localparam int LIN_W    = 18;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 4;

    localparam int MAX_TEMPLATES_DEF = 16;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [LIN_W-1:0]  lin;
    } entry_t;

endpackage

[sv/tsl_in_if.sv]
// Request channel of the template select block: valid/ready plus command payload.
// Depends on tsl_pkg.
interface tsl_in_if;
    logic                        valid;
    logic                        ready;
    logic [tsl_pkg::CMD_W-1:0]   cmd;
    logic [tsl_pkg::AREA_W-1:0]  entry_area;
    logic [tsl_pkg::LIN_W-1:0]   entry_linearity;
    logic [tsl_pkg::AREA_W-1:0]  query_value;

    modport source (output valid, cmd, entry_area, entry_linearity, query_value,
                    input ready);
    modport sink   (input valid, cmd, entry_area, entry_linearity, query_value,
                    output ready);
endinterface

[sv/tsl_out_if.sv]
// Result channel of the template select block: valid/ready plus result payload.
// Depends on tsl_pkg.
interface tsl_out_if;
    logic                          valid;
    logic                          ready;
    logic [tsl_pkg::STATUS_W-1:0]  status;
    logic [tsl_pkg::INDEX_W-1:0]   template_index;
    logic [tsl_pkg::LIN_W-1:0]     linearity_out;

    modport source (output valid, status, template_index, linearity_out,
                    input ready);
    modport sink   (input valid, status, template_index, linearity_out,
                    output ready);
endinterface

[sv/template_select_linearity_interp.sv]
// Template select with linearity interpolation. Holds a table of up to
// MAX_TEMPLATES entries (area, linearity) in one synchronous memory with one
// write and one read port. One item is processed at a time; the result sits in
// an output register so the next item can be taken while it waits. A load
// also rewrites the previous interior entry's midpoint when there is one. A
// query scans the table one entry read at a time (S_QRD, then S_QCMP). It
// returns the entry's linearity at the ends and interpolates otherwise, with
// a multiply step plus an 18-step restoring divider for the ratio.
// Depends on tsl_pkg, tsl_in_if and tsl_out_if.
module template_select_linearity_interp #(
    parameter int MAX_TEMPLATES = tsl_pkg::MAX_TEMPLATES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tsl_in_if.sink    request,
    tsl_out_if.source result
);

    localparam int IDX_W  = (MAX_TEMPLATES > 1) ? $clog2(MAX_TEMPLATES) : 1;
    localparam int CNT_W  = $clog2(MAX_TEMPLATES + 1);
    localparam int AW     = tsl_pkg::AREA_W;
    localparam int LW     = tsl_pkg::LIN_W;
    localparam int PROD_W = AW + LW;
    localparam int STEP_W = $clog2(LW + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LMID,
        S_QRD,
        S_QCMP,
        S_MUL,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

    state_t state_reg;

    // latched request
    logic [tsl_pkg::CMD_W-1:0] cmd_reg;
    logic [AW-1:0]             area_reg;
    logic [LW-1:0]             lin_reg;
    logic [AW-1:0]             q_reg;

    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] idx_reg;
    tsl_pkg::entry_t  prev_reg;

    // interpolation datapath
    logic [AW-1:0]     span_reg;
    logic [AW-1:0]     off_reg;
    logic [LW-1:0]     dl_reg;
    logic              neg_reg;
    logic [LW-1:0]     lo_lin_reg;
    logic [AW-1:0]     rem_reg;
    logic [LW-1:0]     low_reg;
    logic [STEP_W-1:0] step_reg;

    // pending result and output register
    logic [tsl_pkg::STATUS_W-1:0] res_status_reg;
    logic [IDX_W-1:0]             res_idx_reg;
    logic [LW-1:0]                res_lin_reg;
    logic                         out_valid_reg;
    logic [tsl_pkg::STATUS_W-1:0] out_status_reg;
    logic [tsl_pkg::INDEX_W-1:0]  out_idx_reg;
    logic [LW-1:0]                out_lin_reg;

    // table memory
    tsl_pkg::entry_t mem [MAX_TEMPLATES];
    tsl_pkg::entry_t rdata_reg;
    logic            we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    tsl_pkg::entry_t wdata;

    logic [CNT_W-1:0] cnt_m1;
    logic [IDX_W-1:0] last;
    logic             full;
    logic [AW:0]      sum_area;
    logic [LW:0]      sum_lin;
    logic [PROD_W-1:0] prod;
    logic [AW:0]      trial;
    logic             qbit;
    logic [IDX_W+tsl_pkg::INDEX_W-1:0] idx_wide;

    assign cnt_m1 = count_reg - CNT_W'(1);
    assign last   = cnt_m1[IDX_W-1:0];
    assign full   = (count_reg >= CNT_W'(MAX_TEMPLATES));

    assign sum_area = {1'b0, rdata_reg.area} + {1'b0, area_reg};
    assign sum_lin  = {1'b0, rdata_reg.lin} + {1'b0, lin_reg};

    assign prod  = PROD_W'(off_reg) * PROD_W'(dl_reg);
    assign trial = {rem_reg, low_reg[LW-1]};
    assign qbit  = (trial >= {1'b0, span_reg});

    always_comb
    begin
        we          = 1'b0;
        waddr       = idx_reg;
        wdata.area  = area_reg;
        wdata.lin   = lin_reg;
        raddr       = idx_reg;
        if (state_reg == S_DISPATCH)
        begin
            raddr = last;
            if (cmd_reg == tsl_pkg::CMD_LOAD && !full)
            begin
                we    = 1'b1;
                waddr = count_reg[IDX_W-1:0];
            end
        end
        else if (state_reg == S_LMID)
        begin
            we         = 1'b1;
            wdata.area = sum_area[AW:1];
            wdata.lin  = sum_lin[LW:1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && request.valid)
        begin
            cmd_reg  <= request.cmd;
            area_reg <= request.entry_area;
            lin_reg  <= request.entry_linearity;
            q_reg    <= request.query_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            prev_reg       <= '0;
            span_reg       <= '0;
            off_reg        <= '0;
            dl_reg         <= '0;
            neg_reg        <= 1'b0;
            lo_lin_reg     <= '0;
            rem_reg        <= '0;
            low_reg        <= '0;
            step_reg       <= '0;
            res_status_reg <= tsl_pkg::STATUS_OK;
            res_idx_reg    <= '0;
            res_lin_reg    <= '0;
            out_status_reg <= tsl_pkg::STATUS_OK;
            out_idx_reg    <= '0;
            out_lin_reg    <= '0;
        end
        else
        begin
            // S_OUT reloads the output register itself
            if (out_valid_reg && result.ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (request.valid)
                    begin
                        state_reg <= S_DISPATCH;
                    end
                end

                S_DISPATCH:
                begin
                    res_idx_reg <= '0;
                    res_lin_reg <= '0;
                    unique case (cmd_reg)
                        tsl_pkg::CMD_CLEAR:
                        begin
                            count_reg      <= '0;
                            res_status_reg <= tsl_pkg::STATUS_OK;
                            state_reg      <= S_OUT;
                        end
                        tsl_pkg::CMD_LOAD:
                        begin
                            if (full)
                            begin
                                res_status_reg <= tsl_pkg::STATUS_FULL;
                                state_reg      <= S_OUT;
                            end
                            else
                            begin
                                res_status_reg <= tsl_pkg::STATUS_OK;
                                count_reg      <= count_reg + CNT_W'(1);
                                // previous interior entry gets midpoints
                                if (count_reg >= CNT_W'(2))
                                begin
                                    idx_reg   <= last;
                                    state_reg <= S_LMID;
                                end
                                else
                                begin
                                    state_reg <= S_OUT;
                                end
                            end
                        end
                        tsl_pkg::CMD_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_reg <= tsl_pkg::STATUS_EMPTY;
                                state_reg      <= S_OUT;
                            end
                            else
                            begin
                                res_status_reg <= tsl_pkg::STATUS_OK;
                                idx_reg        <= '0;
                                state_reg      <= S_QRD;
                            end
                        end
                        default:
                        begin
                            res_status_reg <= tsl_pkg::STATUS_OK;
                            state_reg      <= S_OUT;
                        end
                    endcase
                end

                S_LMID:
                begin
                    state_reg <= S_OUT;
                end

                S_QRD:
                begin
                    state_reg <= S_QCMP;
                end

                S_QCMP:
                begin
                    res_idx_reg <= idx_reg;
                    if (idx_reg == last)
                    begin
                        res_lin_reg <= rdata_reg.lin;
                        state_reg   <= S_OUT;
                    end
                    else if (q_reg < rdata_reg.area)
                    begin
                        if (idx_reg == '0)
                        begin
                            res_lin_reg <= rdata_reg.lin;
                            state_reg   <= S_OUT;
                        end
                        else
                        begin
                            span_reg   <= rdata_reg.area - prev_reg.area;
                            off_reg    <= q_reg - prev_reg.area;
                            lo_lin_reg <= prev_reg.lin;
                            if (rdata_reg.lin >= prev_reg.lin)
                            begin
                                neg_reg <= 1'b0;
                                dl_reg  <= rdata_reg.lin - prev_reg.lin;
                            end
                            else
                            begin
                                neg_reg <= 1'b1;
                                dl_reg  <= prev_reg.lin - rdata_reg.lin;
                            end
                            state_reg <= S_MUL;
                        end
                    end
                    else
                    begin
                        prev_reg  <= rdata_reg;
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= S_QRD;
                    end
                end

                S_MUL:
                begin
                    // off < span, so the high part is already below the divisor
                    rem_reg   <= prod[PROD_W-1:LW];
                    low_reg   <= prod[LW-1:0];
                    step_reg  <= STEP_W'(LW);
                    state_reg <= S_DIV;
                end

                S_DIV:
                begin
                    if (qbit)
                    begin
                        rem_reg <= AW'(trial - {1'b0, span_reg});
                    end
                    else
                    begin
                        rem_reg <= trial[AW-1:0];
                    end
                    low_reg  <= {low_reg[LW-2:0], qbit};
                    step_reg <= step_reg - STEP_W'(1);
                    if (step_reg == STEP_W'(1))
                    begin
                        state_reg <= S_FIN;
                    end
                end

                S_FIN:
                begin
                    if (neg_reg)
                    begin
                        res_lin_reg <= lo_lin_reg - low_reg;
                    end
                    else
                    begin
                        res_lin_reg <= lo_lin_reg + low_reg;
                    end
                    state_reg <= S_OUT;
                end

                S_OUT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_idx_reg    <= idx_wide[tsl_pkg::INDEX_W-1:0];
                        out_lin_reg    <= res_lin_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign idx_wide = {{tsl_pkg::INDEX_W{1'b0}}, res_idx_reg};

    assign request.ready         = (state_reg == S_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.status         = out_status_reg;
    assign result.template_index = out_idx_reg;
    assign result.linearity_out  = out_lin_reg;

endmodule

[bench/template_select_linearity_interp_tb.sv]
`timescale 1ns / 100ps
// Testbench for template_select_linearity_interp: directed table loads and lookups,
// then random load/query sessions, checked against an in-bench table predictor.
// Depends on tsl_pkg, tsl_in_if, tsl_out_if and the block itself.
module template_select_linearity_interp_tb;

    localparam int     NUM_ENTRIES  = tsl_pkg::MAX_TEMPLATES_DEF;
    localparam logic [tsl_pkg::CMD_W-1:0]  CMD_UNUSED = 2'd3;
    localparam logic [tsl_pkg::LIN_W-1:0]  LIN_MAX    = {tsl_pkg::LIN_W{1'b1}};
    localparam logic [tsl_pkg::AREA_W-1:0] AREA_MAX   = {tsl_pkg::AREA_W{1'b1}};
    localparam int     RANDOM_ITEMS = 900;
    localparam int     CALM_TAIL    = 100;
    localparam int     DRAIN_CYCLES = 100;
    localparam longint CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [tsl_pkg::STATUS_W-1:0] status;
        logic [tsl_pkg::INDEX_W-1:0]  index;
        logic [tsl_pkg::LIN_W-1:0]    lin;
    } lookup_result_t;

    class lookup_scoreboard;
        logic [tsl_pkg::AREA_W-1:0] upper_area [NUM_ENTRIES];
        logic [tsl_pkg::LIN_W-1:0]  upper_lin  [NUM_ENTRIES];
        int                         entries;
        lookup_result_t             expected_q [$];
        int                         errors;

        function new();
            entries = 0;
            errors  = 0;
        endfunction

        // Linear interpolation between two table points, truncated toward zero.
        function logic [tsl_pkg::LIN_W-1:0] interp_lin(logic [tsl_pkg::AREA_W-1:0] q,
                                                       logic [tsl_pkg::AREA_W-1:0] lo_a,
                                                       logic [tsl_pkg::AREA_W-1:0] hi_a,
                                                       logic [tsl_pkg::LIN_W-1:0] lo_l,
                                                       logic [tsl_pkg::LIN_W-1:0] hi_l);
            longint unsigned span;
            longint unsigned off;
            longint unsigned mag;
            span = longint'(hi_a) - longint'(lo_a);
            off  = longint'(q) - longint'(lo_a);
            if (span == 0)
            begin
                return lo_l;
            end
            if (hi_l >= lo_l)
            begin
                mag = (off * longint'(hi_l - lo_l)) / span;
                return lo_l + mag[tsl_pkg::LIN_W-1:0];
            end
            mag = (off * longint'(lo_l - hi_l)) / span;
            return lo_l - mag[tsl_pkg::LIN_W-1:0];
        endfunction

        function lookup_result_t apply_command(logic [tsl_pkg::CMD_W-1:0] cmd,
                                               logic [tsl_pkg::AREA_W-1:0] area,
                                               logic [tsl_pkg::LIN_W-1:0] lin,
                                               logic [tsl_pkg::AREA_W-1:0] q);
            lookup_result_t res;
            logic [tsl_pkg::AREA_W:0] sum_a;
            logic [tsl_pkg::LIN_W:0]  sum_l;
            int              last;
            int              pick;
            int              prev;
            res = '0;
            case (cmd)
                tsl_pkg::CMD_CLEAR: entries = 0;
                tsl_pkg::CMD_LOAD:
                begin
                    if (entries >= NUM_ENTRIES)
                    begin
                        res.status = tsl_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        // interior predecessor moves to the midpoint
                        if (entries >= 2)
                        begin
                            prev = entries - 1;
                            sum_a = {1'b0, upper_area[prev]} + {1'b0, area};
                            sum_l = {1'b0, upper_lin[prev]} + {1'b0, lin};
                            upper_area[prev] = sum_a[tsl_pkg::AREA_W:1];
                            upper_lin[prev]  = sum_l[tsl_pkg::LIN_W:1];
                        end
                        upper_area[entries] = area;
                        upper_lin[entries]  = lin;
                        entries++;
                    end
                end
                tsl_pkg::CMD_QUERY:
                begin
                    if (entries == 0)
                    begin
                        res.status = tsl_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        last = entries - 1;
                        pick = last;
                        for (int i = 0; i < last; i++)
                        begin
                            if (q < upper_area[i])
                            begin
                                pick = i;
                                break;
                            end
                        end
                        res.index = pick[tsl_pkg::INDEX_W-1:0];
                        if (pick == 0 || pick == last)
                            res.lin = upper_lin[pick];
                        else
                            res.lin = interp_lin(q, upper_area[pick-1], upper_area[pick],
                                                 upper_lin[pick-1], upper_lin[pick]);
                    end
                end
                default: ;
            endcase
            return res;
        endfunction

        function void note_request(logic [tsl_pkg::CMD_W-1:0] cmd,
                                   logic [tsl_pkg::AREA_W-1:0] area,
                                   logic [tsl_pkg::LIN_W-1:0] lin,
                                   logic [tsl_pkg::AREA_W-1:0] q);
            expected_q = {expected_q, apply_command(cmd, area, lin, q)};
        endfunction

        task report_mismatch(string what, longint got, longint want);
            errors++;
            $display("ERROR %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        endtask

        task check_result(logic [tsl_pkg::STATUS_W-1:0] status,
                          logic [tsl_pkg::INDEX_W-1:0] index,
                          logic [tsl_pkg::LIN_W-1:0] lin);
            lookup_result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result with nothing pending, status", status, 0);
                return;
            end
            want = expected_q.pop_front();
            if (status !== want.status)
                report_mismatch("status", status, want.status);
            if (index !== want.index)
                report_mismatch("template_index", index, want.index);
            if (lin !== want.lin)
                report_mismatch("linearity_out", lin, want.lin);
        endtask
    endclass

    logic clk;
    logic rst_n;

    tsl_in_if  request_if ();
    tsl_out_if result_if ();

    template_select_linearity_interp u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_if),
        .result  (result_if)
    );

    lookup_scoreboard sb;
    int               items_sent;
    bit               allow_idle;
    longint           cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // result side: check accepted items, stall ready in random bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready)
                sb.check_result(result_if.status, result_if.template_index,
                                result_if.linearity_out);
            if (!rst_n)
            begin
                result_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_if.ready <= 1'b0;
            end
            else if (allow_idle && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                result_if.ready <= 1'b0;
            end
            else
            begin
                result_if.ready <= 1'b1;
            end
        end
    end

    task automatic push_item(logic [tsl_pkg::CMD_W-1:0] cmd,
                             logic [tsl_pkg::AREA_W-1:0] area,
                             logic [tsl_pkg::LIN_W-1:0] lin,
                             logic [tsl_pkg::AREA_W-1:0] q);
        int gap;
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            request_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_if.valid           <= 1'b1;
        request_if.cmd             <= cmd;
        request_if.entry_area      <= area;
        request_if.entry_linearity <= lin;
        request_if.query_value     <= q;
        do
            @(posedge clk);
        while (!request_if.ready);
        sb.note_request(cmd, area, lin, q);
        items_sent++;
        if (items_sent >= RANDOM_ITEMS - CALM_TAIL)
            allow_idle = 1'b0;
    endtask

    task automatic send_load(logic [tsl_pkg::AREA_W-1:0] area,
                             logic [tsl_pkg::LIN_W-1:0] lin);
        push_item(tsl_pkg::CMD_LOAD, area, lin, $urandom);
    endtask

    task automatic send_query(logic [tsl_pkg::AREA_W-1:0] q);
        push_item(tsl_pkg::CMD_QUERY, $urandom, $urandom_range(0, LIN_MAX), q);
    endtask

    task automatic send_clear();
        push_item(tsl_pkg::CMD_CLEAR, $urandom, $urandom_range(0, LIN_MAX), $urandom);
    endtask

    task automatic send_unused();
        push_item(CMD_UNUSED, $urandom, $urandom_range(0, LIN_MAX), $urandom);
    endtask

    task automatic run_directed();
        send_query(32'h0000_1234);              // empty table
        send_unused();
        send_load(32'h0000_0000, 18'h0_0000);
        send_load(32'h0001_0000, LIN_MAX);
        send_load(32'h0010_0000, 18'h1_0000);
        send_load(AREA_MAX, 18'h2_0000);
        send_query(32'h0000_0000);              // at the first entry's area
        send_query(32'h0008_0000);              // rising interpolation
        send_query(32'h0010_0000);              // falling interpolation
        send_query(AREA_MAX);                   // last entry
        // fill the rest out of order, then overflow
        for (int i = 4; i < NUM_ENTRIES; i++)
            send_load($urandom, $urandom_range(0, LIN_MAX));
        send_load(32'h1234_5678, 18'h1_2345);
        send_query($urandom);
        send_clear();
    endtask

    // one table build followed by lookups; a few are malformed on purpose
    task automatic run_session();
        logic [tsl_pkg::AREA_W-1:0] areas [];
        logic [tsl_pkg::AREA_W-1:0] base;
        logic [tsl_pkg::AREA_W-1:0] q;
        longint unsigned   span;
        int                n;
        int                m;
        int                mode;
        int                r;
        int                j;
        r = $urandom_range(0, 9);
        if (r < 6)
            n = $urandom_range(1, 5);
        else if (r < 9)
            n = $urandom_range(6, NUM_ENTRIES);
        else
            n = $urandom_range(NUM_ENTRIES, NUM_ENTRIES + 3);
        mode = $urandom_range(0, 9);
        base = $urandom;
        areas = new[n];
        for (int i = 0; i < n; i++)
        begin
            if (mode == 0)
                areas[i] = base + $urandom_range(0, 15);
            else
                areas[i] = $urandom;
        end
        if (mode != 1)
            areas.sort();
        if ($urandom_range(0, 9) == 0)
            send_unused();
        if ($urandom_range(0, 7) != 0)
            send_clear();
        if ($urandom_range(0, 9) == 0)
            send_query($urandom);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_load(areas[i], ($urandom_range(0, 1) == 1) ? LIN_MAX : '0);
            else
                send_load(areas[i], $urandom_range(0, LIN_MAX));
        end
        m = $urandom_range(1, 8);
        for (int k = 0; k < m; k++)
        begin
            r = $urandom_range(0, 9);
            j = $urandom_range(0, n - 1);
            if (r == 0 || n == 1)
                q = $urandom;
            else if (r == 1)
                q = areas[j];
            else if (r == 2)
                q = ($urandom_range(0, 1) == 1) ? areas[j] + 1 : areas[j] - 1;
            else if (r == 3)
                q = ($urandom_range(0, 1) == 1) ? AREA_MAX : '0;
            else
            begin
                j = $urandom_range(0, n - 2);
                if (areas[j+1] >= areas[j])
                begin
                    span = longint'(areas[j+1]) - longint'(areas[j]) + 1;
                    q = areas[j] + tsl_pkg::AREA_W'(longint'($urandom) % span);
                end
                else
                begin
                    q = $urandom;
                end
            end
            send_query(q);
        end
        if ($urandom_range(0, 11) == 0)
            send_unused();
    endtask

    initial
    begin
        sb         = new();
        items_sent = 0;
        allow_idle = 1'b1;
        rst_n      = 1'b0;
        request_if.valid           = 1'b0;
        request_if.cmd             = tsl_pkg::CMD_CLEAR;
        request_if.entry_area      = '0;
        request_if.entry_linearity = '0;
        request_if.query_value     = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        while (items_sent < RANDOM_ITEMS)
            run_session();
        request_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
